@@ src/acenc_pkg.sv @@
// ----------------------------------------------------------------------------
// acenc_pkg
// Shared types and constants for the 32-bit arithmetic encoder.
// ----------------------------------------------------------------------------
package acenc_pkg;

    localparam int FREQ_W = 16;
    localparam int Q_W    = 33;
    localparam int CNT_W  = 6;

    localparam logic [31:0] HALF           = 32'h8000_0000;
    localparam logic [31:0] QUARTER        = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTERS = 32'hC000_0000;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_DIV   = 7'b000_0010,
        ST_DRY   = 7'b000_0100,
        ST_RUN   = 7'b000_1000,
        ST_EMIT  = 7'b001_0000,
        ST_FLUSH = 7'b010_0000,
        ST_CLOSE = 7'b100_0000
    } state_t;

    // command from the sequencer to the byte packer
    typedef struct packed {
        logic bit_valid;
        logic bit_val;
        logic flush;
        logic close;
        logic stream_end;
        logic overflow;
    } pk_cmd_t;

    typedef struct packed {
        logic       ready;
        logic       hold_valid;
        logic [2:0] bit_pos;
    } pk_stat_t;

endpackage

@@ src/arithmetic_encoder_32bit.sv @@
// ----------------------------------------------------------------------------
// arithmetic_encoder_32bit
// Low/high arithmetic encoder with pending bits, emitting MSB-first bytes.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_      | in  | tuser: mode; tdata: cdf_low, cdf_high, total
//  m_      | out | tdata: out_byte; tlast: last_of_run; tuser: end, overflow
//
//  Encode: the bit-serial scaler, then a dry renormalization pass that settles
//  the overflow flag, then the renormalization loop that emits each bit and
//  releases the pending bits.
//  Finish: the final bit and its pending bits, then flush and close, then state resets.
//  Output stalls hold the bit loop only when a finished byte cannot move.
//  Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module arithmetic_encoder_32bit #(
    parameter int PENDING_LIMIT = 255,
    parameter int PROB_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cdf_low[15:0], cdf_high[31:16], total[47:32]
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // last_of_run
    output logic [1:0]  m_tuser    // stream_end, pending_overflow
);

    localparam logic [23:0] FMASK24 = 24'((25'(1) << PROB_BITS) - 25'(1));
    localparam logic [15:0] FMASK   = FMASK24[15:0];
    localparam logic [7:0]  PLIM    = 8'(PENDING_LIMIT);

    acenc_pkg::state_t   state_reg, state_next;
    logic [31:0] low_reg, low_next, high_reg, high_next;
    logic [31:0] dlo_reg, dlo_next, dhi_reg, dhi_next;
    logic [7:0]  pc_reg, pc_next, dpc_reg, dpc_next;
    logic        ovs_reg, ovs_next, dov_reg, dov_next;
    logic        bit_reg, bit_next, first_reg, first_next, fin_reg, fin_next;
    logic [15:0] f_lo, f_hi, f_tot;
    logic        in_ok, accept, div_start, div_done;
    logic [acenc_pkg::Q_W-1:0] div_r, q_lo, q_hi;
    acenc_pkg::pk_cmd_t  pk_cmd;
    acenc_pkg::pk_stat_t pk_st;

    assign f_lo   = s_tdata[15:0] & FMASK;
    assign f_hi   = s_tdata[31:16] & FMASK;
    assign f_tot  = s_tdata[47:32] & FMASK;
    assign in_ok  = (f_tot != 16'd0) && (f_lo < f_hi) && (f_hi <= f_tot);
    assign s_tready = (state_reg == acenc_pkg::ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign div_r  = {1'b0, high_reg} - {1'b0, low_reg} + 33'd1;
    assign div_start = accept && (s_tuser[0] == acenc_pkg::MODE_ENCODE) && in_ok;

    acenc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .r_in    (div_r),
        .f_lo    (f_lo),
        .f_hi    (f_hi),
        .tot     (f_tot),
        .done    (div_done),
        .q_lo    (q_lo),
        .q_hi    (q_hi)
    );

    always_comb begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        dlo_next   = dlo_reg;
        dhi_next   = dhi_reg;
        pc_next    = pc_reg;
        dpc_next   = dpc_reg;
        ovs_next   = ovs_reg;
        dov_next   = dov_reg;
        bit_next   = bit_reg;
        first_next = first_reg;
        fin_next   = fin_reg;
        pk_cmd     = '0;
        pk_cmd.overflow   = ovs_reg;
        pk_cmd.stream_end = fin_reg;

        case (state_reg)
            acenc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == acenc_pkg::MODE_FINISH) begin
                        if (pc_reg >= PLIM) ovs_next = 1'b1;
                        else pc_next = pc_reg + 8'd1;
                        bit_next   = (low_reg >= acenc_pkg::QUARTER);
                        first_next = 1'b1;
                        fin_next   = 1'b1;
                        state_next = acenc_pkg::ST_EMIT;
                    end else if (in_ok) begin
                        fin_next   = 1'b0;
                        state_next = acenc_pkg::ST_DIV;
                    end
                end
            end
            acenc_pkg::ST_DIV: begin
                if (div_done) begin
                    high_next  = low_reg + q_hi[31:0] - 32'd1;
                    low_next   = low_reg + q_lo[31:0];
                    dhi_next   = low_reg + q_hi[31:0] - 32'd1;
                    dlo_next   = low_reg + q_lo[31:0];
                    dpc_next   = pc_reg;
                    dov_next   = ovs_reg;
                    state_next = acenc_pkg::ST_DRY;
                end
            end
            // replays renormalization without output to learn the final flag
            acenc_pkg::ST_DRY: begin
                if (dhi_reg < acenc_pkg::HALF || dlo_reg >= acenc_pkg::HALF) begin
                    dpc_next = '0;
                    dlo_next = {dlo_reg[30:0], 1'b0};
                    dhi_next = {dhi_reg[30:0], 1'b1};
                end else if (dlo_reg >= acenc_pkg::QUARTER
                             && dhi_reg < acenc_pkg::THREE_QUARTERS) begin
                    if (dpc_reg >= PLIM) dov_next = 1'b1;
                    else dpc_next = dpc_reg + 8'd1;
                    dlo_next = {dlo_reg[30:0] - acenc_pkg::QUARTER[30:0], 1'b0};
                    dhi_next = {dhi_reg[30:0] - acenc_pkg::QUARTER[30:0], 1'b1};
                end else begin
                    ovs_next   = dov_reg;
                    state_next = acenc_pkg::ST_RUN;
                end
            end
            acenc_pkg::ST_RUN: begin
                if (high_reg < acenc_pkg::HALF) begin
                    bit_next   = 1'b0;
                    first_next = 1'b1;
                    state_next = acenc_pkg::ST_EMIT;
                end else if (low_reg >= acenc_pkg::HALF) begin
                    bit_next   = 1'b1;
                    first_next = 1'b1;
                    state_next = acenc_pkg::ST_EMIT;
                end else if (low_reg >= acenc_pkg::QUARTER
                             && high_reg < acenc_pkg::THREE_QUARTERS) begin
                    if (pc_reg < PLIM) pc_next = pc_reg + 8'd1;
                    low_next  = {low_reg[30:0] - acenc_pkg::QUARTER[30:0], 1'b0};
                    high_next = {high_reg[30:0] - acenc_pkg::QUARTER[30:0], 1'b1};
                end else begin
                    state_next = acenc_pkg::ST_CLOSE;
                end
            end
            // the bit, then the pending bits inverted
            acenc_pkg::ST_EMIT: begin
                pk_cmd.bit_valid = 1'b1;
                pk_cmd.bit_val   = first_reg ? bit_reg : ~bit_reg;
                if (pk_st.ready) begin
                    if (!first_reg) pc_next = pc_reg - 8'd1;
                    first_next = 1'b0;
                    if ((first_reg && pc_reg == 8'd0) || (!first_reg && pc_reg == 8'd1)) begin
                        pc_next = '0;
                        if (fin_reg) begin
                            state_next = acenc_pkg::ST_FLUSH;
                        end else begin
                            // half subtraction drops out with the MSB
                            low_next   = {low_reg[30:0], 1'b0};
                            high_next  = {high_reg[30:0], 1'b1};
                            state_next = acenc_pkg::ST_RUN;
                        end
                    end
                end
            end
            acenc_pkg::ST_FLUSH: begin
                pk_cmd.flush = 1'b1;
                if (pk_st.ready) state_next = acenc_pkg::ST_CLOSE;
            end
            acenc_pkg::ST_CLOSE: begin
                pk_cmd.close = 1'b1;
                if (pk_st.ready) begin
                    if (fin_reg) begin
                        low_next  = '0;
                        high_next = acenc_pkg::ALL_ONES;
                        pc_next   = '0;
                        ovs_next  = 1'b0;
                        fin_next  = 1'b0;
                    end
                    state_next = acenc_pkg::ST_IDLE;
                end
            end
            default: state_next = acenc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        dlo_reg   <= dlo_next;
        dhi_reg   <= dhi_next;
        dpc_reg   <= dpc_next;
        dov_reg   <= dov_next;
        bit_reg   <= bit_next;
        first_reg <= first_next;
        if (!aresetn) begin
            state_reg <= acenc_pkg::ST_IDLE;
            low_reg   <= '0;
            high_reg  <= acenc_pkg::ALL_ONES;
            pc_reg    <= '0;
            ovs_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            pc_reg    <= pc_next;
            ovs_reg   <= ovs_next;
            fin_reg   <= fin_next;
        end
    end

    acenc_pack u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (pk_cmd),
        .stat     (pk_st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_no_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pk_st.hold_valid)
        else $error("held byte left over between items");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("stream end on a byte that is not last");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == acenc_pkg::ST_DIV)
        else $error("scaler finished outside its state");

    a_idle_byte_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) && $past(fin_reg) |-> pk_st.bit_pos == 3'd7)
        else $error("packer not aligned after finish");

endmodule

@@ src/acenc_div.sv @@
// ----------------------------------------------------------------------------
// acenc_div
// Bit-serial scaler: floor(r * f / total) for two frequencies at once, one
// bit of r per cycle, MSB first; remainder stays below total.
// ----------------------------------------------------------------------------
module acenc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [acenc_pkg::Q_W-1:0]      r_in,
    input  logic [acenc_pkg::FREQ_W-1:0]   f_lo,
    input  logic [acenc_pkg::FREQ_W-1:0]   f_hi,
    input  logic [acenc_pkg::FREQ_W-1:0]   tot,
    output logic                           done,
    output logic [acenc_pkg::Q_W-1:0]      q_lo,
    output logic [acenc_pkg::Q_W-1:0]      q_hi
);

    logic [acenc_pkg::Q_W-1:0]    r_reg, r_next;
    logic [acenc_pkg::Q_W-1:0]    ql_reg, ql_next, qh_reg, qh_next;
    logic [acenc_pkg::FREQ_W-1:0] rl_reg, rl_next, rh_reg, rh_next;
    logic [acenc_pkg::FREQ_W-1:0] fl_reg, fh_reg, t_reg, fl_next, fh_next, t_next;
    logic [acenc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         busy_reg, busy_next, done_reg, done_next;
    logic [17:0] sl, sh, t1, t2;
    logic [1:0]  dl, dh;
    logic [17:0] rl_w, rh_w;

    always_comb begin
        t1 = {2'b00, t_reg};
        t2 = {1'b0, t_reg, 1'b0};
        sl = {1'b0, rl_reg, 1'b0} + (r_reg[acenc_pkg::Q_W-1] ? {2'b00, fl_reg} : 18'd0);
        sh = {1'b0, rh_reg, 1'b0} + (r_reg[acenc_pkg::Q_W-1] ? {2'b00, fh_reg} : 18'd0);
        // quotient digit is 0, 1 or 2 since f <= total
        if (sl >= t2) begin
            dl = 2'd2; rl_w = sl - t2;
        end else if (sl >= t1) begin
            dl = 2'd1; rl_w = sl - t1;
        end else begin
            dl = 2'd0; rl_w = sl;
        end
        if (sh >= t2) begin
            dh = 2'd2; rh_w = sh - t2;
        end else if (sh >= t1) begin
            dh = 2'd1; rh_w = sh - t1;
        end else begin
            dh = 2'd0; rh_w = sh;
        end

        r_next    = r_reg;
        ql_next   = ql_reg;
        qh_next   = qh_reg;
        rl_next   = rl_reg;
        rh_next   = rh_reg;
        fl_next   = fl_reg;
        fh_next   = fh_reg;
        t_next    = t_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            r_next    = r_in;
            ql_next   = '0;
            qh_next   = '0;
            rl_next   = '0;
            rh_next   = '0;
            fl_next   = f_lo;
            fh_next   = f_hi;
            t_next    = tot;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = {r_reg[acenc_pkg::Q_W-2:0], 1'b0};
            ql_next  = {ql_reg[acenc_pkg::Q_W-2:0], 1'b0} + {31'd0, dl};
            qh_next  = {qh_reg[acenc_pkg::Q_W-2:0], 1'b0} + {31'd0, dh};
            rl_next  = rl_w[acenc_pkg::FREQ_W-1:0];
            rh_next  = rh_w[acenc_pkg::FREQ_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == acenc_pkg::CNT_W'(acenc_pkg::Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_reg   <= r_next;
        ql_reg  <= ql_next;
        qh_reg  <= qh_next;
        rl_reg  <= rl_next;
        rh_reg  <= rh_next;
        fl_reg  <= fl_next;
        fh_reg  <= fh_next;
        t_reg   <= t_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign q_lo = ql_reg;
    assign q_hi = qh_reg;

endmodule

@@ src/acenc_pack.sv @@
// ----------------------------------------------------------------------------
// acenc_pack
// Byte packer: shifts bits in MSB first, holds one finished byte back so the
// last byte of an item can be marked, and drives the output register.
// ----------------------------------------------------------------------------
module acenc_pack (
    input  logic                aclk,
    input  logic                aresetn,
    input  acenc_pkg::pk_cmd_t  cmd,
    output acenc_pkg::pk_stat_t stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);

    logic [7:0] part_reg, part_next, hold_reg, hold_next;
    logic [2:0] pos_reg, pos_next;
    logic       hv_reg, hv_next;
    logic       ov_reg, ov_next, oe_reg, oe_next, ol_reg, ol_next;
    logic [7:0] od_reg, od_next;
    logic       ovf_reg, ovf_next;
    logic       slot_free, complete, flushing, push, ready;
    logic [7:0] new_byte;

    always_comb begin
        slot_free = !ov_reg || m_tready;
        complete  = cmd.bit_valid && (pos_reg == 3'd0);
        flushing  = cmd.flush && (pos_reg != 3'd7);
        push      = hv_reg && (complete || flushing || cmd.close);
        ready     = !push || slot_free;
        new_byte  = part_reg | (8'(cmd.bit_val) << pos_reg);

        part_next = part_reg;
        pos_next  = pos_reg;
        hold_next = hold_reg;
        hv_next   = hv_reg;
        if (ready) begin
            if (cmd.bit_valid) begin
                if (pos_reg == 3'd0) begin
                    hold_next = new_byte;
                    hv_next   = 1'b1;
                    part_next = '0;
                    pos_next  = 3'd7;
                end else begin
                    part_next = new_byte;
                    pos_next  = pos_reg - 3'd1;
                end
            end else if (flushing) begin
                hold_next = part_reg;
                hv_next   = 1'b1;
                part_next = '0;
                pos_next  = 3'd7;
            end else if (cmd.close) begin
                hv_next = 1'b0;
            end
        end

        ov_next  = ov_reg;
        od_next  = od_reg;
        ol_next  = ol_reg;
        oe_next  = oe_reg;
        ovf_next = ovf_reg;
        if (push && slot_free) begin
            ov_next  = 1'b1;
            od_next  = hold_reg;
            ol_next  = cmd.close;
            oe_next  = cmd.close && cmd.stream_end;
            ovf_next = cmd.overflow;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
        oe_reg   <= oe_next;
        ovf_reg  <= ovf_next;
        if (!aresetn) begin
            part_reg <= '0;
            pos_reg  <= 3'd7;
            hv_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            part_reg <= part_next;
            pos_reg  <= pos_next;
            hv_reg   <= hv_next;
            ov_reg   <= ov_next;
        end
    end

    assign stat.ready      = ready;
    assign stat.hold_valid = hv_reg;
    assign stat.bit_pos    = pos_reg;
    assign m_tvalid        = ov_reg;
    assign m_tdata         = od_reg;
    assign m_tlast         = ol_reg;
    assign m_tuser         = {ovf_reg, oe_reg};

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 32-bit arithmetic encoder: a directed table of
// symbols and finishes, then random symbol streams with saturation bursts,
// all scored against a local interval-coder model with random idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_ITEMS    = 430;
    localparam int CYCLE_CAP  = 2000000;
    localparam int HOLD_LEN   = 3000;
    localparam int DRAIN_WAIT = 400;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       send;
        logic       ovf;
    } code_byte_t;

    typedef struct {
        logic        mode;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] tot;
        bit          typed;
        logic [7:0]  tbyte;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // cdf_low[15:0], cdf_high[31:16], total[47:32]
    logic [0:0]  s_tuser = '0;  // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;       // out_byte
    logic        m_tlast;       // last_of_run
    logic [1:0]  m_tuser;       // stream_end, pending_overflow

    arithmetic_encoder_32bit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // coder model state
    logic [31:0] cm_low;
    logic [31:0] cm_high;
    int          cm_pending;
    logic [7:0]  cm_partial;
    int          cm_bitpos;
    bit          cm_ovf;

    code_byte_t  code_q[$];
    code_byte_t  new_bytes[$];
    int          n_errors = 0;
    int          cycles = 0;
    bit          hold_req = 1'b0;
    bit          no_idle = 1'b0;
    stim_row_t   dir_tab[14];

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic void coder_clear();
        cm_low     = 32'h0;
        cm_high    = acenc_pkg::ALL_ONES;
        cm_pending = 0;
        cm_partial = 8'h0;
        cm_bitpos  = 7;
        cm_ovf     = 1'b0;
    endfunction

    function automatic void put_code_bit(logic b);
        code_byte_t cb;
        cm_partial[cm_bitpos] = b;
        if (cm_bitpos == 0) begin
            cb.code = cm_partial;
            cb.last = 1'b0;
            cb.send = 1'b0;
            cb.ovf  = 1'b0;
            new_bytes.push_back(cb);
            cm_partial = 8'h0;
            cm_bitpos  = 7;
        end else begin
            cm_bitpos--;
        end
    endfunction

    function automatic void put_with_followers(logic b);
        put_code_bit(b);
        for (int i = 0; i < cm_pending; i++)
            put_code_bit(~b);
        cm_pending = 0;
    endfunction

    function automatic void bump_pending();
        if (cm_pending >= 255)
            cm_ovf = 1'b1;
        else
            cm_pending++;
    endfunction

    // returns 0 when the item is an invalid symbol and gets ignored
    function automatic bit code_item(logic mode, logic [15:0] lo, logic [15:0] hi,
                                     logic [15:0] tot);
        logic [63:0] span;
        logic [31:0] qh;
        logic [31:0] ql;
        code_byte_t  cb;
        bit          flag;
        new_bytes.delete();
        if (mode == acenc_pkg::MODE_ENCODE) begin
            if (tot == 0 || lo >= hi || hi > tot)
                return 0;
            span = {32'h0, cm_high} - {32'h0, cm_low} + 64'd1;
            qh = 32'((span * hi) / tot);
            ql = 32'((span * lo) / tot);
            cm_high = cm_low + qh - 32'd1;
            cm_low  = cm_low + ql;
            forever begin
                if (cm_high < acenc_pkg::HALF) begin
                    put_with_followers(1'b0);
                end else if (cm_low >= acenc_pkg::HALF) begin
                    put_with_followers(1'b1);
                    cm_low  -= acenc_pkg::HALF;
                    cm_high -= acenc_pkg::HALF;
                end else if (cm_low >= acenc_pkg::QUARTER
                             && cm_high < acenc_pkg::THREE_QUARTERS) begin
                    bump_pending();
                    cm_low  -= acenc_pkg::QUARTER;
                    cm_high -= acenc_pkg::QUARTER;
                end else begin
                    break;
                end
                cm_low  = cm_low << 1;
                cm_high = (cm_high << 1) | 32'd1;
            end
            flag = cm_ovf;
        end else begin
            bump_pending();
            put_with_followers(cm_low < acenc_pkg::QUARTER ? 1'b0 : 1'b1);
            if (cm_bitpos < 7) begin
                cb.code = cm_partial;
                new_bytes.push_back(cb);
            end
            flag = cm_ovf;
            coder_clear();
        end
        foreach (new_bytes[k]) begin
            new_bytes[k].ovf  = flag;
            new_bytes[k].last = (k == new_bytes.size() - 1);
            new_bytes[k].send = (k == new_bytes.size() - 1) ? mode : 1'b0;
        end
        return 1;
    endfunction

    // offer one item, wait for acceptance, then queue what it should yield
    task automatic send_item(logic mode, logic [15:0] lo, logic [15:0] hi,
                             logic [15:0] tot, bit typed, logic [7:0] tbyte,
                             output bit valid_sym);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {tot, hi, lo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        valid_sym = code_item(mode, lo, hi, tot);
        if (typed && new_bytes.size() == 1)
            new_bytes[0].code = tbyte;
        foreach (new_bytes[k]) code_q.push_back(new_bytes[k]);
    endtask

    // receiver: random stall per item, plus one long hold-off on request
    initial begin
        int w;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_req = 1'b0;
            end
            w = no_idle ? 0 : $urandom_range(0, 8);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        code_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (code_q.size() == 0) begin
                $display("%0t: unexpected byte %h last %b user %b", $time,
                         m_tdata, m_tlast, m_tuser);
                n_errors++;
            end else begin
                want = code_q.pop_front();
                if (m_tdata !== want.code || m_tlast !== want.last ||
                    m_tuser !== {want.ovf, want.send}) begin
                    $display("%0t: mismatch exp byte %h last %b user %b, got %h %b %b",
                             $time, want.code, want.last, {want.ovf, want.send},
                             m_tdata, m_tlast, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        bit          ok;
        int          n_sent;
        int          kind;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] tot;
        int          waited;

        // finish right after reset: pending 1 bit after a 0 gives 0x40
        dir_tab[0]  = '{acenc_pkg::MODE_FINISH, 16'h0, 16'h0, 16'h0, 1'b1, 8'h40};
        dir_tab[1]  = '{acenc_pkg::MODE_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'h40};
        dir_tab[2]  = '{acenc_pkg::MODE_ENCODE, 16'h0, 16'h1, 16'h0, 1'b0, 8'h0};  // zero total
        dir_tab[3]  = '{acenc_pkg::MODE_ENCODE, 16'h5, 16'h5, 16'h10, 1'b0, 8'h0}; // empty symbol
        dir_tab[4]  = '{acenc_pkg::MODE_ENCODE, 16'h1, 16'h11, 16'h10, 1'b0, 8'h0}; // above total
        dir_tab[5]  = '{acenc_pkg::MODE_ENCODE, 16'h0, 16'h1, 16'hFFFF, 1'b0, 8'h0};
        dir_tab[6]  = '{acenc_pkg::MODE_ENCODE, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0, 8'h0};
        dir_tab[7]  = '{acenc_pkg::MODE_ENCODE, 16'h0, 16'hFFFF, 16'hFFFF, 1'b0, 8'h0};
        dir_tab[8]  = '{acenc_pkg::MODE_ENCODE, 16'h0, 16'h1, 16'h1, 1'b0, 8'h0};
        dir_tab[9]  = '{acenc_pkg::MODE_ENCODE, 16'h1, 16'h3, 16'h4, 1'b0, 8'h0}; // straddles middle
        dir_tab[10] = '{acenc_pkg::MODE_ENCODE, 16'h7FFE, 16'h8000, 16'hFFFF, 1'b0, 8'h0};
        dir_tab[11] = '{acenc_pkg::MODE_FINISH, 16'hAAAA, 16'h5555, 16'h0, 1'b0, 8'h0};
        dir_tab[12] = '{acenc_pkg::MODE_ENCODE, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0, 8'h0};
        dir_tab[13] = '{acenc_pkg::MODE_FINISH, 16'h0, 16'h0, 16'h0, 1'b0, 8'h0};

        coder_clear();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].mode, dir_tab[i].lo, dir_tab[i].hi, dir_tab[i].tot,
                      dir_tab[i].typed, dir_tab[i].tbyte, ok);

        // drive the pending count into saturation, then close the stream
        for (int i = 0; i < 25; i++)
            send_item(acenc_pkg::MODE_ENCODE, 16'h7FFE, 16'h8000, 16'hFFFF, 1'b0, 8'h0, ok);
        send_item(acenc_pkg::MODE_FINISH, 16'h0, 16'h0, 16'h0, 1'b0, 8'h0, ok);

        n_sent = 0;
        while (n_sent < N_ITEMS) begin
            if (n_sent % 80 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (n_sent == 120)
                hold_req = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                send_item(acenc_pkg::MODE_FINISH, 16'($urandom), 16'($urandom),
                          16'($urandom), 1'b0, 8'h0, ok);
            end else if (kind < 14) begin
                // noise: raw random fields, mostly invalid symbols
                send_item(acenc_pkg::MODE_ENCODE, 16'($urandom), 16'($urandom),
                          16'($urandom), 1'b0, 8'h0, ok);
            end else if (kind < 24) begin
                send_item(acenc_pkg::MODE_ENCODE, 16'h7FFE + 16'($urandom_range(0, 1)),
                          16'h8000, 16'hFFFF, 1'b0, 8'h0, ok);
            end else begin
                tot = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 64));
                lo  = 16'($urandom_range(0, tot - 1));
                hi  = 16'($urandom_range(lo + 1, tot));
                send_item(acenc_pkg::MODE_ENCODE, lo, hi, tot, 1'b0, 8'h0, ok);
            end
            n_sent++;
        end
        send_item(acenc_pkg::MODE_FINISH, 16'h0, 16'h0, 16'h0, 1'b0, 8'h0, ok);
        @(posedge aclk);
        s_tvalid <= 1'b0;

        waited = 0;
        while (code_q.size() != 0 && waited < CYCLE_CAP) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (n_errors == 0 && code_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
